@@ hdl/melody_text_to_midi_events_top_assert.svh @@
// Assertion macros for the melody text to MIDI event converter.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef MELODY_TEXT_TO_MIDI_EVENTS_TOP_ASSERT_SVH
`define MELODY_TEXT_TO_MIDI_EVENTS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mtm_pkg.sv @@
// Shared types and constants of the melody text to MIDI event converter.
// No dependencies; used by every module of the block.
package mtm_pkg;

  localparam int unsigned QDepth    = 2;
  localparam int unsigned QAddrW    = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned SlotCount = 11;
  localparam int unsigned SlotW     = $clog2(SlotCount);

  localparam logic [7:0] StatusOn  = 8'h90;
  localparam logic [7:0] StatusOff = 8'h80;
  localparam logic [7:0] Velocity  = 8'h60;
  localparam logic [7:0] MetaByte  = 8'hFF;
  localparam logic [7:0] EndOfTrk  = 8'h2F;

  // Tokeniser phase of the front end.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OCT,
    PH_SHARP,
    PH_FLAT,
    PH_DUR
  } phase_e;

  // Byte slots that one job may expand into, in emission order.
  typedef enum logic [SlotW-1:0] {
    SL_LEAD,
    SL_STAT,
    SL_NUM,
    SL_VEL,
    SL_DHI,
    SL_DLO,
    SL_E0,
    SL_E1,
    SL_E2,
    SL_E3,
    SL_ABT
  } slot_e;

  // One classified input word as handed from the front to the back end.
  typedef struct packed {
    logic       lead;     // leading zero delta
    logic       note;     // note event
    logic       rest;     // note event uses the note-off status
    logic [6:0] num;      // note number
    logic [8:0] dur;      // duration in ticks
    logic       fin;      // end-of-track sequence
    logic       abort;    // abort word for a bad octave digit
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/mtm_queue.sv @@
// Short job queue between the front and the back end.
// Depends on mtm_pkg for the job type and depth constants.
module mtm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mtm_pkg::job_t      job_i,
  input  logic               pop_i,
  output mtm_pkg::job_t      job_o,
  output mtm_pkg::q_status_t status_o
);

  mtm_pkg::job_t                 mem_q [mtm_pkg::QDepth];
  logic [mtm_pkg::QAddrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mtm_pkg::QAddrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mtm_pkg::QCntW-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + mtm_pkg::QCntW'(push_i) - mtm_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == mtm_pkg::QCntW'(mtm_pkg::QDepth));
  assign status_o.empty = (count_q == '0);

endmodule

@@ hdl/mtm_front.sv @@
// Front end: accepts melody characters, tracks the token state and
// classifies each word into a job. Depends on mtm_pkg.
module mtm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] text_char
  input  logic               s_axis_tlast_i,   // text_last
  input  mtm_pkg::q_status_t q_status_i,
  output logic               push_o,
  output mtm_pkg::job_t      job_o
);

  mtm_pkg::phase_e phase_q, phase_d;
  logic [1:0]      oct_q, oct_d;
  logic            rest_q, rest_d;
  logic [6:0]      note_q, note_d;
  logic            started_q, started_d;
  logic            aborted_q, aborted_d;

  logic            accept;
  logic [7:0]      c;
  logic            last;

  // Result of taking one character.
  mtm_pkg::phase_e tk_phase;
  logic            tk_bad;
  logic            tk_emit;
  logic [8:0]      tk_dur;
  logic [1:0]      tk_oct;
  logic            tk_rest;
  logic [6:0]      tk_note;
  logic [7:0]      oct_diff;
  logic [4:0]      off;
  logic            fin_bad;
  logic            fin_note;

  function automatic logic [4:0] plain_off(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    case (ch)
      "c": r = 5'd0;
      "d": r = 5'd2;
      "e": r = 5'd4;
      "f": r = 5'd5;
      "g": r = 5'd7;
      "a": r = 5'd9;
      "b": r = 5'd11;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] sharp_off(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    case (ch)
      "c": r = 5'd1;
      "d": r = 5'd3;
      "f": r = 5'd6;
      "g": r = 5'd8;
      "a": r = 5'd10;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] flat_off(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    case (ch)
      "d": r = 5'd1;
      "e": r = 5'd3;
      "g": r = 5'd6;
      "a": r = 5'd8;
      "b": r = 5'd10;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] ticks(input logic [7:0] ch);
    logic [8:0] r;
    r = 9'd0;
    case (ch)
      "0": r = 9'd280;
      "1": r = 9'd140;
      "2": r = 9'd70;
      "3": r = 9'd35;
      "4": r = 9'd18;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = ~q_status_i.full;
  assign c               = s_axis_tdata_i;
  assign last            = s_axis_tlast_i;
  assign oct_diff        = c - 8'h33;

  // Character decode.  Bit 4 of an offset marks an unknown letter.
  always_comb begin
    tk_phase = phase_q;
    tk_bad   = 1'b0;
    tk_emit  = 1'b0;
    tk_dur   = ticks(c);
    tk_oct   = oct_q;
    tk_rest  = rest_q;
    off      = 5'h10;
    unique case (phase_q)
      mtm_pkg::PH_OCT: begin
        if (c >= "3" && c <= "6") begin
          tk_oct   = oct_diff[1:0];
          tk_phase = mtm_pkg::PH_IDLE;
        end else begin
          tk_bad = 1'b1;
        end
      end
      mtm_pkg::PH_SHARP: begin
        off      = sharp_off(c);
        tk_phase = mtm_pkg::PH_DUR;
      end
      mtm_pkg::PH_FLAT: begin
        off      = flat_off(c);
        tk_phase = mtm_pkg::PH_DUR;
      end
      mtm_pkg::PH_DUR: begin
        tk_emit  = 1'b1;
        tk_phase = mtm_pkg::PH_IDLE;
      end
      default: begin
        if (c == "*") begin
          tk_phase = mtm_pkg::PH_OCT;
        end else if (c == "#") begin
          tk_phase = mtm_pkg::PH_SHARP;
        end else if (c == "&") begin
          tk_phase = mtm_pkg::PH_FLAT;
        end else begin
          if (c == "r") begin
            tk_rest = 1'b1;
          end else begin
            off = plain_off(c);
          end
          tk_phase = mtm_pkg::PH_DUR;
        end
      end
    endcase
    tk_note = note_q;
    if (!off[4]) begin
      tk_rest = 1'b0;
      tk_note = 7'd48 + {3'b000, off[3:0]} + {2'b00, tk_oct, 3'b000}
              + {3'b000, tk_oct, 2'b00};
    end
    // A melody that ends inside a token finishes it as if NUL followed.
    fin_bad  = last && !tk_bad && (tk_phase == mtm_pkg::PH_OCT);
    fin_note = last && !tk_bad && (tk_phase != mtm_pkg::PH_OCT)
            && (tk_phase != mtm_pkg::PH_IDLE);
  end

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    oct_d     = oct_q;
    rest_d    = rest_q;
    note_d    = note_q;
    started_d = started_q;
    aborted_d = aborted_q;
    if (accept) begin
      if (last) begin
        phase_d   = mtm_pkg::PH_IDLE;
        oct_d     = 2'd1;
        rest_d    = 1'b0;
        note_d    = '0;
        started_d = 1'b0;
        aborted_d = 1'b0;
      end else if (!aborted_q) begin
        phase_d   = tk_phase;
        oct_d     = tk_oct;
        rest_d    = tk_rest;
        note_d    = tk_note;
        started_d = 1'b1;
        aborted_d = tk_bad;
      end
    end
  end

  // Job towards the back end.
  always_comb begin
    job_o.lead  = ~started_q;
    job_o.note  = tk_emit | fin_note;
    job_o.rest  = tk_rest;
    job_o.num   = tk_note;
    job_o.dur   = tk_emit ? tk_dur : 9'd0;
    job_o.abort = tk_bad | fin_bad;
    job_o.fin   = last & ~tk_bad & ~fin_bad;
    push_o      = accept & ~aborted_q
                & (job_o.lead | job_o.note | job_o.abort | job_o.fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mtm_pkg::PH_IDLE;
      oct_q     <= 2'd1;
      rest_q    <= 1'b0;
      note_q    <= '0;
      started_q <= 1'b0;
      aborted_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      oct_q     <= oct_d;
      rest_q    <= rest_d;
      note_q    <= note_d;
      started_q <= started_d;
      aborted_q <= aborted_d;
    end
  end

endmodule

@@ hdl/mtm_back.sv @@
// Back end: expands queued jobs into track bytes, one word per cycle while
// the receiver takes them, through a registered output stage. Depends on mtm_pkg.
module mtm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtm_pkg::job_t      job_i,
  input  mtm_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [7:0] out_byte
  output logic               m_axis_tlast_o,   // run_last
  output logic [1:0]         m_axis_tuser_o    // [0] track_end, [1] bad_octave
);

  localparam int unsigned N = mtm_pkg::SlotCount;

  logic [N-1:0]   mask_q, mask_d;
  logic [N-1:0]   rem;
  logic [N-1:0]   job_mask;
  logic           rest_q;
  logic [6:0]     num_q;
  logic [8:0]     dur_q;
  mtm_pkg::slot_e sel;
  logic           emit;
  logic           load;
  logic [7:0]     byte_val;

  logic           ovalid_q, ovalid_d;
  logic [7:0]     odata_q;
  logic           olast_q;
  logic [1:0]     ouser_q;

  always_comb begin
    job_mask                    = '0;
    job_mask[mtm_pkg::SL_LEAD]  = job_i.lead;
    job_mask[mtm_pkg::SL_STAT]  = job_i.note;
    job_mask[mtm_pkg::SL_NUM]   = job_i.note;
    job_mask[mtm_pkg::SL_VEL]   = job_i.note;
    job_mask[mtm_pkg::SL_DHI]   = job_i.note & (job_i.dur[8:7] != 2'b00);
    job_mask[mtm_pkg::SL_DLO]   = job_i.note;
    job_mask[mtm_pkg::SL_E0]    = job_i.fin;
    job_mask[mtm_pkg::SL_E1]    = job_i.fin;
    job_mask[mtm_pkg::SL_E2]    = job_i.fin;
    job_mask[mtm_pkg::SL_E3]    = job_i.fin;
    job_mask[mtm_pkg::SL_ABT]   = job_i.abort;
  end

  // Lowest pending slot is the next byte.
  always_comb begin
    sel = mtm_pkg::SL_LEAD;
    for (int i = N - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = mtm_pkg::slot_e'(mtm_pkg::SlotW'(i));
      end
    end
  end

  always_comb begin
    unique case (sel)
      mtm_pkg::SL_STAT: byte_val = rest_q ? mtm_pkg::StatusOff : mtm_pkg::StatusOn;
      mtm_pkg::SL_NUM:  byte_val = {1'b0, num_q};
      mtm_pkg::SL_VEL:  byte_val = mtm_pkg::Velocity;
      mtm_pkg::SL_DHI:  byte_val = {6'b100000, dur_q[8:7]};
      mtm_pkg::SL_DLO:  byte_val = {1'b0, dur_q[6:0]};
      mtm_pkg::SL_E1:   byte_val = mtm_pkg::MetaByte;
      mtm_pkg::SL_E2:   byte_val = mtm_pkg::EndOfTrk;
      default:          byte_val = 8'h00;
    endcase
  end

  assign rem  = mask_q & (mask_q - N'(1));
  assign emit = (mask_q != '0) & (~ovalid_q | m_axis_tready_i);
  // A new job is taken when the current one has nothing left to send.
  assign load = ~q_status_i.empty & ((mask_q == '0) | (emit & (rem == '0)));
  assign pop_o = load;

  always_comb begin
    mask_d = mask_q;
    if (emit) begin
      mask_d = rem;
    end
    if (load) begin
      mask_d = job_mask;
    end
    ovalid_d = emit ? 1'b1 : (m_axis_tready_i ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rest_q <= job_i.rest;
      num_q  <= job_i.num;
      dur_q  <= job_i.dur;
    end
    if (emit) begin
      odata_q    <= byte_val;
      olast_q    <= (rem == '0);
      ouser_q[0] <= (sel == mtm_pkg::SL_E3) | (sel == mtm_pkg::SL_ABT);
      ouser_q[1] <= (sel == mtm_pkg::SL_ABT);
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ouser_q;

endmodule

@@ hdl/melody_text_to_midi_events_top.sv @@
// Melody text to MIDI track-body converter, top level.
//
// Input stream: one melody character per word on s_axis (tdata = character,
// tlast = final character of the melody). Output stream: one track-body byte
// per word on m_axis (tdata = byte, tlast = last byte caused by one input
// word, tuser[0] = byte completes the track or an abort, tuser[1] = abort
// for a bad octave digit).
// The front end takes a character per cycle while the two-entry job queue
// has room; the back end sends one byte per cycle while the receiver takes
// them, and an input word causes up to nine bytes. Rate is set by the
// single byte lane of the back end.
// An accepted character's job passes through the queue, the slot mask and the output register.
// Reset clears the token state, octave 1, and empties queue and output.
// When the receiver stalls the output word holds, the queue fills, and
// then s_axis_tready drops until bytes drain again.
`include "melody_text_to_midi_events_top_assert.svh"

module melody_text_to_midi_events_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_char
  input  logic       s_axis_tlast_i,   // text_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // run_last
  output logic [1:0] m_axis_tuser_o    // [0] track_end, [1] bad_octave
);

  mtm_pkg::job_t      push_job;
  mtm_pkg::job_t      head_job;
  mtm_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  mtm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .job_o          (push_job)
  );

  mtm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .status_o(q_status)
  );

  mtm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (head_job),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Assertions.
  `MTM_ASSERT_NOW(a_no_overflow, push, !q_status.full, "job pushed into a full queue")
  `MTM_ASSERT_NOW(a_no_underflow, pop, !q_status.empty, "job popped from an empty queue")
  `MTM_ASSERT_NOW(a_abort_word, m_axis_tvalid_o && m_axis_tuser_o[1],
                  (m_axis_tdata_o == 8'h00) && m_axis_tlast_o && m_axis_tuser_o[0],
                  "malformed abort word")
  `MTM_ASSERT_NEXT(a_push_fills, push && !pop && q_status.empty, !q_status.empty,
                   "queue lost a pushed job")

endmodule
